/* src/rcx_pkg.sv */
package rcx_pkg;

	localparam int FRAME_LEN = 14;
	localparam int POS_W = 4;
	localparam int TICK_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_BIT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF_PERIOD = 2'd1;

	localparam logic [TICK_W-1:0] HALF_BIT_TICKS_RESET = 16'd7112;
	localparam logic [TICK_W-1:0] CARRIER_HALF_PERIOD_RESET = 16'd144;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

	// Command handed from the front to the back through the queue.
	typedef struct packed {
		logic                 start;
		logic [FRAME_LEN-1:0] frame;
	} cmd_t;

	// One result beat.
	typedef struct packed {
		logic ir_level;
		logic busy_res;
		logic frame_done;
		logic rejected;
	} res_t;

	// True when the given half of the given bit carries the carrier.
	// A zero bit marks in its first half, a one bit in its second half.
	function automatic logic in_mark(logic [FRAME_LEN-1:0] f, logic [POS_W-1:0] pos,
		logic second_half);
		logic b;
		b = f[LAST_POS - pos];
		return second_half ? b : ~b;
	endfunction

endpackage

/* src/rcx_front.sv */
module rcx_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [4:0]          address,
	input  logic                toggle,
	input  logic [5:0]          command,
	output logic                head_valid,
	output rcx_pkg::cmd_t       head,
	input  logic                pop
);

	rcx_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	rcx_pkg::cmd_t cmd;
	logic          push;
	logic          take;

	// The frame is built here, so the back only shifts out bits.
	always_comb begin
		cmd.start = action;
		cmd.frame = {2'b11, toggle, address, command};
	end

	assign in_ready   = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign take       = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, take})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* src/rcx_back.sv */
module rcx_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [rcx_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rcx_pkg::TICK_W-1:0]           cfg_data,
	input  logic                                 head_valid,
	input  rcx_pkg::cmd_t                        head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output rcx_pkg::res_t                        res
);

	logic [rcx_pkg::TICK_W-1:0]    hbt_q;
	logic [rcx_pkg::TICK_W-1:0]    cph_q;
	logic [rcx_pkg::FRAME_LEN-1:0] frame_q;
	logic [rcx_pkg::POS_W-1:0]     pos_q;
	logic                          sh_q;
	logic [rcx_pkg::TICK_W-1:0]    hc_q;
	logic [rcx_pkg::TICK_W-1:0]    cc_q;
	logic                          ph_q;
	logic                          send_q;
	logic                          out_valid_q;
	rcx_pkg::res_t                 res_q;

	logic [rcx_pkg::FRAME_LEN-1:0] n_frame;
	logic [rcx_pkg::POS_W-1:0]     n_pos;
	logic                          n_sh;
	logic [rcx_pkg::TICK_W-1:0]    n_hc;
	logic [rcx_pkg::TICK_W-1:0]    n_cc;
	logic                          n_ph;
	logic                          n_send;
	logic [rcx_pkg::TICK_W-1:0]    hc1;
	logic [rcx_pkg::TICK_W-1:0]    cc1;
	rcx_pkg::res_t                 n_res;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		n_frame = frame_q;
		n_pos   = pos_q;
		n_sh    = sh_q;
		n_hc    = hc_q;
		n_cc    = cc_q;
		n_ph    = ph_q;
		n_send  = send_q;
		n_res   = '0;
		hc1     = hc_q + 16'd1;
		cc1     = cc_q + 16'd1;
		if (head.start) begin
			if (send_q) begin
				n_res.rejected = 1'b1;
			end else begin
				n_frame = head.frame;
				n_pos   = '0;
				n_sh    = 1'b0;
				n_send  = 1'b1;
				n_hc    = '0;
				n_cc    = '0;
				n_ph    = rcx_pkg::in_mark(head.frame, '0, 1'b0);
			end
		end else if (send_q) begin
			// A counter that wraps to zero also ends the interval.
			if (hc1 == '0 || hc1 >= hbt_q) begin
				n_hc = '0;
				n_cc = '0;
				if (sh_q) begin
					n_sh = 1'b0;
					if (pos_q >= rcx_pkg::LAST_POS) begin
						n_send = 1'b0;
						n_res.frame_done = 1'b1;
						n_pos = '0;
						n_ph  = 1'b0;
					end else begin
						n_pos = pos_q + 4'd1;
						n_ph  = rcx_pkg::in_mark(frame_q, pos_q + 4'd1, 1'b0);
					end
				end else begin
					n_sh = 1'b1;
					n_ph = rcx_pkg::in_mark(frame_q, pos_q, 1'b1);
				end
			end else begin
				n_hc = hc1;
				if (rcx_pkg::in_mark(frame_q, pos_q, sh_q)) begin
					if (cc1 == '0 || cc1 >= cph_q) begin
						n_cc = '0;
						n_ph = ~ph_q;
					end else begin
						n_cc = cc1;
					end
				end
			end
		end
		n_res.busy_res = n_send;
		n_res.ir_level = n_send && n_ph && rcx_pkg::in_mark(n_frame, n_pos, n_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbt_q <= rcx_pkg::HALF_BIT_TICKS_RESET;
			cph_q <= rcx_pkg::CARRIER_HALF_PERIOD_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == rcx_pkg::CFG_HALF_BIT_TICKS) begin
				hbt_q <= cfg_data;
			end else if (cfg_index == rcx_pkg::CFG_CARRIER_HALF_PERIOD) begin
				cph_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			pos_q       <= '0;
			sh_q        <= 1'b0;
			hc_q        <= '0;
			cc_q        <= '0;
			ph_q        <= 1'b0;
			send_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				frame_q <= n_frame;
				pos_q   <= n_pos;
				sh_q    <= n_sh;
				hc_q    <= n_hc;
				cc_q    <= n_cc;
				ph_q    <= n_ph;
				send_q  <= n_send;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= n_res;
		end
	end

endmodule

/* src/rc5_ir_frame_transmitter.sv */
// RC5 infrared frame transmitter.
// Input channel (in_valid/in_ready): each beat is either one time tick
// (action = 0) or a request to start a frame (action = 1) carrying address,
// toggle and command. Every input beat yields exactly one output beat on the
// out_valid/out_ready channel: the diode level after that item, the busy flag,
// frame_done on the tick that ends the last half-bit, and rejected for a start
// request that arrives while a frame is still going out.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 sets the ticks per
// half-bit, index 1 the ticks between carrier toggles; other indexes are ignored.
// Write only while the block is idle.
// Timing: an accepted beat goes into a two-entry queue; the frame engine takes
// one entry per cycle into its output register while the receiver is ready, so
// the result passes the queue entry and then the result register, and one beat
// per cycle is sustained while out_ready holds. The engine's state update
// (two counter increments and compares, combinational) sets that rate.
// When the receiver stalls, the result register holds, the queue fills and
// in_ready drops after two more beats. Reset clears the queue, the output
// valid flag and the frame state, and loads the register defaults (7112, 144).
module rc5_ir_frame_transmitter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rcx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rcx_pkg::TICK_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [4:0]                    address,
	input  logic                          toggle,
	input  logic [5:0]                    command,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ir_level,
	output logic                          busy_res,
	output logic                          frame_done,
	output logic                          rejected
);

	logic          head_valid;
	rcx_pkg::cmd_t head;
	logic          pop;
	rcx_pkg::res_t res;

	assign cfg_ready = 1'b1;

	rcx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.toggle     (toggle),
		.command    (command),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	rcx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign ir_level   = res.ir_level;
	assign busy_res   = res.busy_res;
	assign frame_done = res.frame_done;
	assign rejected   = res.rejected;

endmodule

/* src/rcx_checker.sv */
module rcx_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic ir_level,
	input logic busy_res,
	input logic frame_done,
	input logic rejected
);

	// A stalled result beat keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({ir_level, busy_res, frame_done, rejected}))
		else $error("result changed while stalled");

	// The last half-bit leaves the block idle and dark.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> !busy_res && !ir_level && !rejected)
		else $error("frame_done with busy or lit output");

	// A request is only refused while a frame is in progress, which continues.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res)
		else $error("rejected while idle");

	// The diode is never lit outside a frame.
	a_level_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ir_level |-> busy_res)
		else $error("ir_level high while idle");

endmodule

bind rc5_ir_frame_transmitter rcx_checker u_rcx_checker (.*);
